>>> sv/fcte_pkg.sv
// Shared types, codes and format helpers for the FAT cluster table engine.
package fcte_pkg;

    localparam int ENTRY_W = 28;

    localparam logic [2:0] OP_GET_NEXT   = 3'd0;
    localparam logic [2:0] OP_GET_EXTEND = 3'd1;
    localparam logic [2:0] OP_WRITE      = 3'd2;
    localparam logic [2:0] OP_ALLOCATE   = 3'd3;
    localparam logic [2:0] OP_COUNT_FREE = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CORRUPT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] FAT12 = 2'd0;
    localparam logic [1:0] FAT16 = 2'd1;
    localparam logic [1:0] FAT32 = 2'd2;

    localparam logic [0:0] CFG_FAT_TYPE      = 1'b0;
    localparam logic [0:0] CFG_CLUSTER_COUNT = 1'b1;

    localparam logic [1:0]  FAT_TYPE_RESET      = FAT32;
    localparam logic [15:0] CLUSTER_COUNT_RESET = 16'd65534;
    localparam logic [15:0] FREE_HINT_RESET     = 16'd2;

    localparam logic [ENTRY_W-1:0] MASK12    = 28'h0000fff;
    localparam logic [ENTRY_W-1:0] MASK16    = 28'h000ffff;
    localparam logic [ENTRY_W-1:0] MASK32    = 28'hfffffff;
    localparam logic [ENTRY_W-1:0] EOC12     = 28'h0000ff8;
    localparam logic [ENTRY_W-1:0] EOC16     = 28'h000fff8;
    localparam logic [ENTRY_W-1:0] EOC32     = 28'hffffff8;
    localparam logic [ENTRY_W-1:0] EOC_MARK  = 28'hfffffff;

    typedef struct packed {
        logic [2:0]         operation;
        logic [15:0]        cluster;
        logic [ENTRY_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ENTRY_W-1:0] next_cluster;
        logic               end_of_chain;
        logic [15:0]        free_count;
    } out_item_t;

    function automatic logic [ENTRY_W-1:0] width_mask(input logic [1:0] ft);
        logic [ENTRY_W-1:0] m;
        unique case (ft)
            FAT12:   m = MASK12;
            FAT16:   m = MASK16;
            default: m = MASK32;
        endcase
        return m;
    endfunction

    function automatic logic [ENTRY_W-1:0] end_start(input logic [1:0] ft);
        logic [ENTRY_W-1:0] s;
        unique case (ft)
            FAT12:   s = EOC12;
            FAT16:   s = EOC16;
            default: s = EOC32;
        endcase
        return s;
    endfunction

endpackage

>>> sv/fcte_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fcte_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/fat_cluster_table_engine_core.sv
// FAT cluster table engine: chain lookup, next-fit allocation and free count.
//
// Input channel in_valid/in_ready/in_data carries one request beat (operation,
// cluster, value); output channel out_valid/out_ready/out_data returns exactly
// one result beat per request. The config port (cfg_write, cfg_index,
// cfg_data) sets the table format and cluster count, to be written while idle
// (the core does not enforce this). One request is in work at a time. Get next
// (and extend on a normal entry) and write entry first read the table RAM, then
// check or write back. Cluster 0 get next, reserved operations, clusters past
// the table and count free with a known count are answered from the accept
// state alone. Allocation walks the table from the hint, one entry per cycle
// with pipelined reads; the first count free walks all data clusters. Extend on
// an end-of-chain entry reads it, walks like allocation, then links the new
// cluster to the old tail in a last step. After reset the engine clears all
// min(TABLE_ENTRIES, 65536) entries of the table RAM, one entry per cycle,
// before in_ready rises.
// Results go to an output register; a new request is taken while a result
// waits, and when the receiver stalls the next result is held until the
// output register frees.
module fat_cluster_table_engine_core #(
    parameter int TABLE_ENTRIES = 65536
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fcte_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fcte_pkg::out_item_t out_data,
    input  logic                cfg_write,
    input  logic [0:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam int MEM_DEPTH = (TABLE_ENTRIES > 65536) ? 65536 : TABLE_ENTRIES;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int EW        = fcte_pkg::ENTRY_W;
    localparam logic [16:0]       MEM_DEPTH_L = 17'(MEM_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(MEM_DEPTH - 1);
    localparam logic [ADDR_W-1:0] FIRST_DATA  = ADDR_W'(2);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCAN,
        S_LINK,
        S_HOLD
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_ptr_reg, clr_ptr_next;
    logic [2:0]          op_reg, op_next;
    logic [15:0]         cl_reg, cl_next;
    logic [EW-1:0]       val_reg, val_next;
    logic [EW-1:0]       link_raw_reg, link_raw_next;
    logic                extend_reg, extend_next;
    logic                count_mode_reg, count_mode_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    logic [15:0]         left_reg, left_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [ADDR_W-1:0]   chk_addr_reg, chk_addr_next;
    logic [15:0]         tally_reg, tally_next;
    logic [ADDR_W-1:0]   nc_reg, nc_next;
    logic [15:0]         free_hint_reg, free_hint_next;
    logic [15:0]         free_total_reg, free_total_next;
    logic                count_valid_reg, count_valid_next;
    logic [1:0]          fat_type_reg, fat_type_next;
    logic [15:0]         cluster_count_reg, cluster_count_next;
    logic                out_valid_reg, out_valid_next;
    fcte_pkg::out_item_t out_reg, out_next;
    fcte_pkg::out_item_t pend_reg, pend_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [EW-1:0]     wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [EW-1:0]     rd_data;

    logic [EW-1:0]       m;
    logic [EW-1:0]       es;
    logic [EW-1:0]       rd_entry;
    logic [EW-1:0]       nv;
    logic [16:0]         cc_plus2;
    logic [16:0]         lim;
    logic [15:0]         scan_total;
    logic                hint_ok;
    logic [ADDR_W-1:0]   start_ptr;
    logic [ADDR_W-1:0]   ptr_adv;
    logic                in_table;
    logic                out_free;
    logic                hit;
    logic [15:0]         tally_now;
    logic                res_fire;
    fcte_pkg::out_item_t res;

    fcte_ram #(
        .WIDTH(EW),
        .DEPTH(MEM_DEPTH)
    ) u_table (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign m          = fcte_pkg::width_mask(fat_type_reg);
    assign es         = fcte_pkg::end_start(fat_type_reg);
    assign rd_entry   = rd_data & m;
    assign cc_plus2   = {1'b0, cluster_count_reg} + 17'd2;
    assign lim        = (cc_plus2 > MEM_DEPTH_L) ? MEM_DEPTH_L : cc_plus2;
    assign scan_total = 16'(lim - 17'd2);
    assign hint_ok    = (free_hint_reg >= 16'd2) && ({1'b0, free_hint_reg} < lim);
    assign start_ptr  = hint_ok ? free_hint_reg[ADDR_W-1:0] : FIRST_DATA;
    assign ptr_adv    = (({{(17 - ADDR_W){1'b0}}, ptr_reg} + 17'd1) == lim)
                        ? FIRST_DATA : ptr_reg + ADDR_W'(1);
    assign in_table   = {1'b0, in_data.cluster} < MEM_DEPTH_L;
    assign out_free   = !out_valid_reg || out_ready;
    assign hit        = chk_valid_reg && (rd_entry == '0) && !count_mode_reg;
    assign tally_now  = tally_reg
                        + {15'd0, count_mode_reg && chk_valid_reg && (rd_entry == '0)};

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next         = state_reg;
        clr_ptr_next       = clr_ptr_reg;
        op_next            = op_reg;
        cl_next            = cl_reg;
        val_next           = val_reg;
        link_raw_next      = link_raw_reg;
        extend_next        = extend_reg;
        count_mode_next    = count_mode_reg;
        ptr_next           = ptr_reg;
        left_next          = left_reg;
        chk_valid_next     = chk_valid_reg;
        chk_addr_next      = chk_addr_reg;
        tally_next         = tally_reg;
        nc_next            = nc_reg;
        free_hint_next     = free_hint_reg;
        free_total_next    = free_total_reg;
        count_valid_next   = count_valid_reg;
        fat_type_next      = fat_type_reg;
        cluster_count_next = cluster_count_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        out_next           = out_reg;
        pend_next          = pend_reg;
        wr_en              = 1'b0;
        wr_addr            = '0;
        wr_data            = '0;
        rd_en              = 1'b0;
        rd_addr            = '0;
        nv                 = '0;
        res_fire           = 1'b0;
        res                = '0;

        if (cfg_write)
        begin
            unique case (cfg_index)
                fcte_pkg::CFG_FAT_TYPE:      fat_type_next = cfg_data[1:0];
                fcte_pkg::CFG_CLUSTER_COUNT: cluster_count_next = cfg_data;
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_ptr_reg;
                if (clr_ptr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_ptr_next = clr_ptr_reg + ADDR_W'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = in_data.operation;
                    cl_next         = in_data.cluster;
                    val_next        = in_data.value;
                    extend_next     = 1'b0;
                    count_mode_next = 1'b0;
                    chk_valid_next  = 1'b0;
                    ptr_next        = start_ptr;
                    left_next       = scan_total;
                    tally_next      = '0;
                    unique case (in_data.operation) inside
                        fcte_pkg::OP_GET_NEXT, fcte_pkg::OP_GET_EXTEND:
                        begin
                            if (in_data.cluster == '0)
                            begin
                                if (in_data.operation == fcte_pkg::OP_GET_NEXT)
                                begin
                                    res_fire   = 1'b1;
                                    res.status = fcte_pkg::ST_CORRUPT;
                                end
                                else
                                begin
                                    state_next = S_SCAN;
                                end
                            end
                            else if (in_table)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = in_data.cluster[ADDR_W-1:0];
                                state_next = S_READ;
                            end
                            else
                            begin
                                res_fire   = 1'b1;
                                res.status = fcte_pkg::ST_CORRUPT;
                            end
                        end
                        fcte_pkg::OP_WRITE:
                        begin
                            if (in_table)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = in_data.cluster[ADDR_W-1:0];
                                state_next = S_READ;
                            end
                            else
                            begin
                                res_fire = 1'b1;
                            end
                        end
                        fcte_pkg::OP_ALLOCATE:
                        begin
                            state_next = S_SCAN;
                        end
                        fcte_pkg::OP_COUNT_FREE:
                        begin
                            if (count_valid_reg)
                            begin
                                res_fire       = 1'b1;
                                res.free_count = free_total_reg;
                            end
                            else
                            begin
                                count_mode_next = 1'b1;
                                ptr_next        = FIRST_DATA;
                                state_next      = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_fire = 1'b1;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                if (op_reg == fcte_pkg::OP_WRITE)
                begin
                    nv       = val_reg & m;
                    wr_en    = 1'b1;
                    wr_addr  = cl_reg[ADDR_W-1:0];
                    wr_data  = (rd_data & ~m) | nv;
                    res_fire = 1'b1;
                    if (rd_entry != '0 && nv == '0)
                    begin
                        if (count_valid_reg && free_total_reg != 16'hffff)
                        begin
                            free_total_next = free_total_reg + 16'd1;
                        end
                    end
                    else if (rd_entry == '0 && nv != '0)
                    begin
                        if (count_valid_reg && free_total_reg != '0)
                        begin
                            free_total_next = free_total_reg - 16'd1;
                        end
                    end
                end
                else if (rd_entry == '0)
                begin
                    res_fire   = 1'b1;
                    res.status = fcte_pkg::ST_CORRUPT;
                end
                else if (rd_entry >= es)
                begin
                    if (op_reg == fcte_pkg::OP_GET_NEXT)
                    begin
                        res_fire         = 1'b1;
                        res.next_cluster = fcte_pkg::EOC_MARK;
                        res.end_of_chain = 1'b1;
                    end
                    else
                    begin
                        link_raw_next = rd_data;
                        extend_next   = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
                else
                begin
                    res_fire         = 1'b1;
                    res.next_cluster = rd_entry;
                end
            end

            S_SCAN:
            begin
                tally_next = tally_now;
                if (hit)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = chk_addr_reg;
                    wr_data        = rd_data | m;
                    free_hint_next = 16'(chk_addr_reg);
                    nc_next        = chk_addr_reg;
                    chk_valid_next = 1'b0;
                    if (count_valid_reg && free_total_reg != '0)
                    begin
                        free_total_next = free_total_reg - 16'd1;
                    end
                    if (extend_reg)
                    begin
                        state_next = S_LINK;
                    end
                    else
                    begin
                        res_fire         = 1'b1;
                        res.next_cluster = EW'(chk_addr_reg);
                    end
                end
                else if (left_reg == '0)
                begin
                    chk_valid_next = 1'b0;
                    res_fire       = 1'b1;
                    if (count_mode_reg)
                    begin
                        free_total_next  = tally_now;
                        count_valid_next = 1'b1;
                        res.free_count   = tally_now;
                    end
                    else
                    begin
                        res.status = fcte_pkg::ST_FULL;
                    end
                end
                else
                begin
                    rd_en          = 1'b1;
                    rd_addr        = ptr_reg;
                    chk_valid_next = 1'b1;
                    chk_addr_next  = ptr_reg;
                    ptr_next       = ptr_adv;
                    left_next      = left_reg - 16'd1;
                end
            end

            S_LINK:
            begin
                nv               = EW'(nc_reg) & m;
                wr_en            = 1'b1;
                wr_addr          = cl_reg[ADDR_W-1:0];
                wr_data          = (link_raw_reg & ~m) | nv;
                res_fire         = 1'b1;
                res.next_cluster = EW'(nc_reg);
                if (nv == '0 && count_valid_reg && free_total_reg != 16'hffff)
                begin
                    free_total_next = free_total_reg + 16'd1;
                end
            end

            S_HOLD:
            begin
                if (out_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (res_fire)
        begin
            if (out_free)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                pend_next  = res;
                state_next = S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            clr_ptr_reg       <= '0;
            op_reg            <= '0;
            cl_reg            <= '0;
            val_reg           <= '0;
            link_raw_reg      <= '0;
            extend_reg        <= 1'b0;
            count_mode_reg    <= 1'b0;
            ptr_reg           <= '0;
            left_reg          <= '0;
            chk_valid_reg     <= 1'b0;
            chk_addr_reg      <= '0;
            tally_reg         <= '0;
            nc_reg            <= '0;
            free_hint_reg     <= fcte_pkg::FREE_HINT_RESET;
            free_total_reg    <= '0;
            count_valid_reg   <= 1'b0;
            fat_type_reg      <= fcte_pkg::FAT_TYPE_RESET;
            cluster_count_reg <= fcte_pkg::CLUSTER_COUNT_RESET;
            out_valid_reg     <= 1'b0;
            out_reg           <= '0;
            pend_reg          <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            clr_ptr_reg       <= clr_ptr_next;
            op_reg            <= op_next;
            cl_reg            <= cl_next;
            val_reg           <= val_next;
            link_raw_reg      <= link_raw_next;
            extend_reg        <= extend_next;
            count_mode_reg    <= count_mode_next;
            ptr_reg           <= ptr_next;
            left_reg          <= left_next;
            chk_valid_reg     <= chk_valid_next;
            chk_addr_reg      <= chk_addr_next;
            tally_reg         <= tally_next;
            nc_reg            <= nc_next;
            free_hint_reg     <= free_hint_next;
            free_total_reg    <= free_total_next;
            count_valid_reg   <= count_valid_next;
            fat_type_reg      <= fat_type_next;
            cluster_count_reg <= cluster_count_next;
            out_valid_reg     <= out_valid_next;
            out_reg           <= out_next;
            pend_reg          <= pend_next;
        end
    end

endmodule
